/* rtl/core/crle_pkg.sv */
// Package with the shared types and constants of the Catmull-Rom loop evaluator.
package crle_pkg;
	localparam int GUARD_BITS = 8;
	localparam int T_BITS = 16;
	localparam int OUT_BITS = 24;
	localparam int CNT_BITS = 5;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;
	localparam logic signed [OUT_BITS-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_BITS-1:0] OUT_MIN = -24'sh800000;
endpackage

/* rtl/core/catmull_rom_loop_evaluator.sv */
// Top level of the pipelined closed-loop Catmull-Rom evaluator.
//
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------------------
// s_axis   | in        | tvalid/tready         | tuser=kind, tdata=index,x,y,z,param
// m_axis   | out       | tvalid/tready         | tdata=pos_x,y,z,tangent_x,y,z
// cfg      | in        | cfg_valid/cfg_ready   | cfg_data=loop length
//
// One transaction is accepted per cycle while the output is not stalled. An evaluate
// transaction passes the registers of stages 1 to 10 and then the output register; the
// chain is long because of the registered multiplies of Horner's rule (three steps, each a multiply and a round/add).
// A load transaction produces no result; it travels two stages and writes the point
// store at the same place where evaluates read it, so the order of transactions holds.
// Reset clears only the valid bits and the loop length (to five); the point store is
// not cleared. A stall on the output freezes the whole pipeline, nothing is lost.
module catmull_rom_loop_evaluator #(
	parameter int MAX_POINTS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata bits from low: point_index[3:0], coord_x, coord_y, coord_z, curve_param
	input  logic [((4 + 3*COORD_BITS + 16 + 7)/8)*8-1:0] s_axis_tdata,
	// tuser: kind
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata bits from low: pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z
	output logic [143:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [crle_pkg::CNT_BITS-1:0] cfg_data
);
	localparam int IDX_BITS = $clog2(MAX_POINTS);
	localparam int NB = $clog2(MAX_POINTS + 1);
	// Coefficients: a = 2*M*p scaled by guard bits; magnitude up to 12*p*2^8.
	localparam int CW = COORD_BITS + 5 + crle_pkg::GUARD_BITS;
	localparam int HW = CW + 3;
	localparam int PW = HW + crle_pkg::T_BITS + 1;
	localparam int STAGES = 11;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [HW-1:0] acc_t;

	// The pipeline advances whenever the output register can take a new value.
	logic adv;
	logic [STAGES-1:0] vld_q;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = vld_q[STAGES-1];

	logic [crle_pkg::CNT_BITS-1:0] loop_len_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_len_q <= crle_pkg::CNT_BITS'(5);
		end else if (cfg_valid && cfg_ready) begin
			loop_len_q <= cfg_data;
		end
	end

	// Effective count clamped to the range 1..MAX_POINTS.
	logic [NB-1:0] n_eff;
	always_comb begin
		if (loop_len_q == '0) n_eff = NB'(1);
		else if (32'(loop_len_q) > MAX_POINTS) n_eff = NB'(MAX_POINTS);
		else n_eff = NB'(loop_len_q);
	end

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	logic [3:0] slot;
	coord_t cx, cy, cz;
	logic [15:0] param;
	assign slot = s_axis_tdata[3:0];
	assign cx = s_axis_tdata[4 +: COORD_BITS];
	assign cy = s_axis_tdata[4 + COORD_BITS +: COORD_BITS];
	assign cz = s_axis_tdata[4 + 2*COORD_BITS +: COORD_BITS];
	assign param = s_axis_tdata[4 + 3*COORD_BITS +: 16];

	// Loads travel with the pipeline so that they reach the store in order with evaluates.
	logic ld_s1, ld_s2;
	logic [3:0] slot_s1, slot_s2;
	coord_t cx_s1, cy_s1, cz_s1, cx_s2, cy_s2, cz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1 <= 1'b0;
			ld_s2 <= 1'b0;
		end else if (adv) begin
			ld_s1 <= in_acc && s_axis_tuser == crle_pkg::KIND_LOAD;
			ld_s2 <= ld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= slot; cx_s1 <= cx; cy_s1 <= cy; cz_s1 <= cz;
			slot_s2 <= slot_s1; cx_s2 <= cx_s1; cy_s2 <= cy_s1; cz_s2 <= cz_s1;
		end
	end

	// Point store: four read ports, so kept as registers per coordinate.
	coord_t mem_x [MAX_POINTS];
	coord_t mem_y [MAX_POINTS];
	coord_t mem_z [MAX_POINTS];
	always_ff @(posedge clk) begin
		if (adv && ld_s2 && 32'(slot_s2) < MAX_POINTS) begin
			mem_x[IDX_BITS'(slot_s2)] <= cx_s2;
			mem_y[IDX_BITS'(slot_s2)] <= cy_s2;
			mem_z[IDX_BITS'(slot_s2)] <= cz_s2;
		end
	end

	// Stage 1: param * count.
	logic [16+NB-1:0] prod_s1;
	logic [NB-1:0] n_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= (16+NB)'(param) * (16+NB)'(n_eff);
			n_s1 <= n_eff;
		end
	end

	// Stage 2: segment indices (integer part < n, so no modulo is needed).
	logic [NB-1:0] seg;
	logic [IDX_BITS-1:0] i0, i1, i2, i3;
	assign seg = prod_s1[16 +: NB];
	always_comb begin
		logic [NB:0] t;
		t = (NB+1)'(seg) + (NB+1)'(n_s1) - (NB+1)'(1);
		if (t >= (NB+1)'(n_s1)) t = t - (NB+1)'(n_s1);
		i0 = IDX_BITS'(t);
		t = t + (NB+1)'(1);
		if (t >= (NB+1)'(n_s1)) t = t - (NB+1)'(n_s1);
		i1 = IDX_BITS'(t);
		t = t + (NB+1)'(1);
		if (t >= (NB+1)'(n_s1)) t = t - (NB+1)'(n_s1);
		i2 = IDX_BITS'(t);
		t = t + (NB+1)'(1);
		if (t >= (NB+1)'(n_s1)) t = t - (NB+1)'(n_s1);
		i3 = IDX_BITS'(t);
	end
	logic [15:0] f_s2;
	logic [IDX_BITS-1:0] idx_s2 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2 <= prod_s1[15:0];
			idx_s2[0] <= i0; idx_s2[1] <= i1; idx_s2[2] <= i2; idx_s2[3] <= i3;
		end
	end

	// Stage 3: fetch the four points of every axis.
	coord_t p_s3 [3][4];
	logic [15:0] f_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3 <= f_s2;
			for (int k = 0; k < 4; k++) begin
				p_s3[0][k] <= mem_x[idx_s2[k]];
				p_s3[1][k] <= mem_y[idx_s2[k]];
				p_s3[2][k] <= mem_z[idx_s2[k]];
			end
		end
	end

	// Stage 4: coefficients (shift-and-add only).
	acc_t a_s4 [3], b_s4 [3], c_s4 [3], d_s4 [3], a3_s4 [3], b2_s4 [3];
	logic [15:0] f_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4 <= f_s3;
			for (int c = 0; c < 3; c++) begin
				acc_t p0, p1, p2, p3, a, b;
				p0 = HW'(p_s3[c][0]); p1 = HW'(p_s3[c][1]);
				p2 = HW'(p_s3[c][2]); p3 = HW'(p_s3[c][3]);
				a = (-p0 + 3*p1 - 3*p2 + p3) <<< crle_pkg::GUARD_BITS;
				b = (2*p0 - 5*p1 + 4*p2 - p3) <<< crle_pkg::GUARD_BITS;
				a_s4[c] <= a;
				b_s4[c] <= b;
				c_s4[c] <= (p2 - p0) <<< crle_pkg::GUARD_BITS;
				d_s4[c] <= (2*p1) <<< crle_pkg::GUARD_BITS;
				a3_s4[c] <= 3*a;
				b2_s4[c] <= 2*b;
			end
		end
	end

	// Horner step: registered multiply, then round and add in the next stage.
	function automatic acc_t rnd16(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] y;
		y = x + PW'(1 <<< 15);
		return HW'(y >>> 16);
	endfunction

	logic signed [PW-1:0] mh_s5 [3], mg_s5 [3], mh_s7 [3], mg_s7 [3], mh_s9 [3];
	acc_t h_s6 [3], g_s6 [3], h_s8 [3], g_s8 [3], h_s10 [3];
	acc_t c_s5 [3], c_s6 [3], c_s7 [3], c_s9 [3];
	acc_t d_s5 [3], d_s6 [3], d_s7 [3], d_s8 [3], d_s9 [3];
	acc_t b_s5 [3], b2_s5 [3];
	logic [15:0] f_s5, f_s6, f_s7, f_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5 <= f_s4; f_s6 <= f_s5; f_s7 <= f_s6; f_s8 <= f_s7;
			for (int c = 0; c < 3; c++) begin
				mh_s5[c] <= PW'(a_s4[c]) * PW'($signed({1'b0, f_s4}));
				mg_s5[c] <= PW'(a3_s4[c]) * PW'($signed({1'b0, f_s4}));
				b_s5[c] <= b_s4[c]; b2_s5[c] <= b2_s4[c];
				c_s5[c] <= c_s4[c]; d_s5[c] <= d_s4[c];
				h_s6[c] <= rnd16(mh_s5[c]) + b_s5[c];
				g_s6[c] <= rnd16(mg_s5[c]) + b2_s5[c];
				c_s6[c] <= c_s5[c]; d_s6[c] <= d_s5[c];
				mh_s7[c] <= PW'(h_s6[c]) * PW'($signed({1'b0, f_s6}));
				mg_s7[c] <= PW'(g_s6[c]) * PW'($signed({1'b0, f_s6}));
				c_s7[c] <= c_s6[c]; d_s7[c] <= d_s6[c];
				h_s8[c] <= rnd16(mh_s7[c]) + c_s7[c];
				g_s8[c] <= rnd16(mg_s7[c]) + c_s7[c];
				d_s8[c] <= d_s7[c];
				mh_s9[c] <= PW'(h_s8[c]) * PW'($signed({1'b0, f_s8}));
				c_s9[c] <= g_s8[c];
				d_s9[c] <= d_s8[c];
				h_s10[c] <= rnd16(mh_s9[c]) + d_s9[c];
			end
		end
	end

	// Final rounding by 2^9 and saturation to 24 bits.
	function automatic logic [23:0] fin(input acc_t x);
		acc_t y;
		y = (x + HW'(1 <<< crle_pkg::GUARD_BITS)) >>> (crle_pkg::GUARD_BITS + 1);
		if (y > HW'(crle_pkg::OUT_MAX)) return crle_pkg::OUT_MAX;
		if (y < HW'(crle_pkg::OUT_MIN)) return crle_pkg::OUT_MIN;
		return y[23:0];
	endfunction

	acc_t g_s10 [3];
	logic [143:0] out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) g_s10[c] <= c_s9[c];
			for (int c = 0; c < 3; c++) begin
				out_q[24*c +: 24] <= fin(h_s10[c]);
				out_q[72 + 24*c +: 24] <= fin(g_s10[c]);
			end
		end
	end
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], in_acc && s_axis_tuser == crle_pkg::KIND_EVAL};
		end
	end
endmodule

/* rtl/core/crle_checker.sv */
// Port-level checker for the Catmull-Rom loop evaluator, bound to the top level.
module crle_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [143:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output");
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({m_axis_tvalid, s_axis_tready}))
		else $error("handshake signal unknown");
endmodule

bind catmull_rom_loop_evaluator crle_checker u_crle_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
